### rtl/hrrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrrs_pkg
// Shared types, grid constants and hex stepping helpers for the ring range set.
// ----------------------------------------------------------------------------
package hrrs_pkg;

  localparam int GRID_WIDTH  = 17;
  localparam int GRID_HEIGHT = 11;
  localparam int MAX_DIST    = 4;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

  localparam int IDX_W   = 8;   // cell index field width
  localparam int DIST_W  = 3;
  localparam int DIR_W   = 3;
  localparam int COORD_W = 7;   // signed, covers walks that leave the grid

  // row = (index * RECIP) >> RECIP_SHIFT, exact for every 8-bit index
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (2 ** RECIP_SHIFT + GRID_WIDTH - 1) / GRID_WIDTH;
  localparam int PROD_W      = IDX_W + RECIP_SHIFT;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t GRID_W_CO = coord_t'(GRID_WIDTH);
  localparam coord_t GRID_H_CO = coord_t'(GRID_HEIGHT);
  localparam logic [IDX_W-1:0] GRID_W_IDX = IDX_W'(GRID_WIDTH);
  localparam logic [IDX_W-1:0] CELL_END   = IDX_W'(CELL_COUNT);
  localparam logic [DIST_W-1:0] MAX_DIST_D = DIST_W'(MAX_DIST);

  localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd5;
  localparam int NUM_DIRS = 6;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0]  center_cell;
    logic [DIST_W-1:0] dist_low;
    logic [DIST_W-1:0] dist_high;
  } req_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic             last_cell;
    logic             none_found;
  } rsp_item_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic div_en;
    logic init_en;
    logic corner_en;
    logic walk_en;
    logic scan_en;
    logic flush_en;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic high_zero;
    logic keep_next;
    logic last_ring_next;
    logic last_ring;
    logic walk_last;
    logic scan_done;
    logic flush_ok;
  } status_t;

  // One step on the offset-row grid; odd rows sit half a cell to the left.
  // Bit 0 of a two's complement row marks odd rows, negative ones included.
  function automatic point_t step_dir(input point_t p, input logic [DIR_W-1:0] dir);
    point_t q;
    logic   odd;
    q   = p;
    odd = p.y[0];
    case (dir)
      DIR_UP_LEFT: begin
        q.x = odd ? p.x - coord_t'(1) : p.x;
        q.y = p.y - coord_t'(1);
      end
      DIR_UP_RIGHT: begin
        q.x = odd ? p.x : p.x + coord_t'(1);
        q.y = p.y - coord_t'(1);
      end
      DIR_RIGHT: begin
        q.x = p.x + coord_t'(1);
      end
      DIR_DOWN_RIGHT: begin
        q.x = odd ? p.x : p.x + coord_t'(1);
        q.y = p.y + coord_t'(1);
      end
      DIR_DOWN_LEFT: begin
        q.x = odd ? p.x - coord_t'(1) : p.x;
        q.y = p.y + coord_t'(1);
      end
      default: begin
        q.x = p.x - coord_t'(1);
      end
    endcase
    return q;
  endfunction

  // Direction of the side that leaves corner v: (v + 2) mod 6
  function automatic logic [DIR_W-1:0] side_dir(input logic [DIR_W-1:0] v);
    logic [DIR_W-1:0] d;
    case (v)
      DIR_UP_LEFT:    d = DIR_RIGHT;
      DIR_UP_RIGHT:   d = DIR_DOWN_RIGHT;
      DIR_RIGHT:      d = DIR_DOWN_LEFT;
      DIR_DOWN_RIGHT: d = DIR_LEFT;
      DIR_DOWN_LEFT:  d = DIR_UP_LEFT;
      default:        d = DIR_UP_RIGHT;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### rtl/hrrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrrs_ctrl
// Sequencer: bitmap clear after reset, request setup, ring walk, scan, flush.
// ----------------------------------------------------------------------------
module hrrs_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  hrrs_pkg::status_t status,
  output hrrs_pkg::cmd_t    cmd
);
  import hrrs_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_INIT   = 8'b0000_1000,
    S_CORNER = 8'b0001_0000,
    S_WALK   = 8'b0010_0000,
    S_SCAN   = 8'b0100_0000,
    S_FLUSH  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init_en = 1'b1;
        state_next  = status.high_zero ? S_SCAN : S_CORNER;
      end
      S_CORNER: begin
        cmd.corner_en = 1'b1;
        if (status.keep_next) begin
          state_next = S_WALK;
        end else if (status.last_ring_next) begin
          state_next = S_SCAN;
        end
      end
      S_WALK: begin
        cmd.walk_en = 1'b1;
        if (status.walk_last) state_next = status.last_ring ? S_SCAN : S_CORNER;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush_en = 1'b1;
        if (status.flush_ok) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/hrrs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrrs_dpath
// Corner and walk registers, mark bitmap, ordered scan and result register.
// ----------------------------------------------------------------------------
module hrrs_dpath (
  input  wire                 clk,
  input  wire                 rst,
  input  hrrs_pkg::cmd_t      cmd,
  output hrrs_pkg::status_t   status,
  input  hrrs_pkg::req_item_t req_data,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output hrrs_pkg::rsp_item_t rsp_data
);
  import hrrs_pkg::*;

  logic [IDX_W-1:0]  center_q;
  logic [DIST_W-1:0] low_q;
  logic [DIST_W-1:0] high_q;
  coord_t            row_q;
  point_t            corners [NUM_DIRS];
  point_t            pt;
  logic [DIST_W-1:0] r_q;
  logic [DIR_W-1:0]  v_q;
  logic [DIST_W-1:0] h_q;

  logic [IDX_W-1:0]  addr;
  logic              rd_valid;
  logic              rd_mark;
  logic [IDX_W-1:0]  rd_idx;
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_idx;

  logic              mark_mem [CELL_COUNT];

  logic [PROD_W-1:0] row_prod;
  logic [IDX_W-1:0]  col_val;
  point_t            center_pt;
  logic              side_end;
  logic [DIR_W-1:0]  v_nx;
  logic              on_grid;
  logic [IDX_W-1:0]  walk_idx;
  logic              issue;
  logic              absorb;
  logic              load_scan;
  logic              load_flush;
  logic              rsp_full_next;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic              mem_wd;

  assign row_prod    = PROD_W'(center_q) * PROD_W'(RECIP);
  assign col_val     = center_q - IDX_W'(IDX_W'($unsigned(row_q)) * GRID_W_IDX);
  assign center_pt.x = coord_t'(col_val);
  assign center_pt.y = row_q;

  assign side_end = (h_q == r_q - DIST_W'(1));
  assign v_nx     = (v_q == DIR_LEFT) ? DIR_UP_LEFT : v_q + DIR_W'(1);
  assign on_grid  = (pt.x >= coord_t'(0)) && (pt.x < GRID_W_CO) &&
                    (pt.y >= coord_t'(0)) && (pt.y < GRID_H_CO);
  assign walk_idx = IDX_W'($unsigned(pt.x)) +
                    IDX_W'(IDX_W'($unsigned(pt.y)) * GRID_W_IDX);

  // scan pipeline: a read is issued only when the result register is free
  // next cycle, so a mark that arrives can always be taken
  assign absorb        = rd_valid && rd_mark;
  assign load_scan     = absorb && pend_valid;
  assign load_flush    = cmd.flush_en && (!rsp_valid || rsp_ready);
  assign rsp_full_next = load_scan || (rsp_valid && !rsp_ready);
  assign issue         = cmd.scan_en && (addr != CELL_END) && !rsp_full_next;

  assign status.clear_last     = (addr == CELL_END - IDX_W'(1));
  assign status.high_zero      = (high_q == '0);
  assign status.keep_next      = ((r_q + DIST_W'(1)) >= low_q);
  assign status.last_ring_next = ((r_q + DIST_W'(1)) == high_q);
  assign status.last_ring      = (r_q == high_q);
  assign status.walk_last      = (v_q == DIR_LEFT) && side_end;
  assign status.scan_done      = (addr == CELL_END) && !rd_valid;
  assign status.flush_ok       = !rsp_valid || rsp_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = 1'b0;
    if (cmd.clear_en) begin
      mem_we = 1'b1;
    end else if (cmd.init_en) begin
      mem_we = (low_q == '0) && (center_q < CELL_END);
      mem_wa = center_q;
      mem_wd = 1'b1;
    end else if (cmd.walk_en) begin
      mem_we = on_grid;
      mem_wa = walk_idx;
      mem_wd = 1'b1;
    end else if (issue) begin
      mem_we = 1'b1;  // read and clear, ready for the next request
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mark_mem[mem_wa] <= mem_wd;
    if (issue) begin
      rd_mark <= mark_mem[addr];
      rd_idx  <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      center_q <= req_data.center_cell;
      low_q    <= req_data.dist_low;
      high_q   <= (req_data.dist_high > MAX_DIST_D) ? MAX_DIST_D : req_data.dist_high;
    end
    if (cmd.div_en) row_q <= coord_t'(row_prod[PROD_W-1:RECIP_SHIFT]);
    if (cmd.init_en) begin
      for (int i = 0; i < NUM_DIRS; i++) corners[i] <= center_pt;
      r_q <= '0;
    end
    if (cmd.corner_en) begin
      for (int i = 0; i < NUM_DIRS; i++) corners[i] <= step_dir(corners[i], DIR_W'(i));
      r_q <= r_q + DIST_W'(1);
      pt  <= step_dir(corners[0], DIR_UP_LEFT);
      v_q <= DIR_UP_LEFT;
      h_q <= '0;
    end
    if (cmd.walk_en) begin
      if (side_end) begin
        h_q <= '0;
        v_q <= v_nx;
        pt  <= corners[v_nx];
      end else begin
        h_q <= h_q + DIST_W'(1);
        pt  <= step_dir(pt, side_dir(v_q));
      end
    end
    if (absorb) pend_idx <= rd_idx;
    if (load_scan) begin
      rsp_data <= '{cell_index: pend_idx, last_cell: 1'b0, none_found: 1'b0};
    end else if (load_flush) begin
      if (pend_valid) begin
        rsp_data <= '{cell_index: pend_idx, last_cell: 1'b1, none_found: 1'b0};
      end else begin
        rsp_data <= '{cell_index: '0, last_cell: 1'b1, none_found: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (cmd.init_en) begin
        addr       <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.clear_en) begin
        addr <= status.clear_last ? '0 : addr + IDX_W'(1);
      end else if (issue) begin
        addr <= addr + IDX_W'(1);
      end
      if (absorb) pend_valid <= 1'b1;
      if (load_scan || load_flush) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/hex_ring_range_set.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after the accepting edge, two setup states (divide, init), then, unless the
//   upper distance is zero, one corner state per ring plus a walk of 6*r cells per kept
//   ring, then a scan of every cell that stalls while the result register is busy, 1 flush.
// Requests: one at a time, the next accepted the cycle after the flush; rsp_ready stalls
//   lengthen the scan and the flush.
// Reset: bitmap clear sweep over every cell after rst, req_ready low until it ends.
// ----------------------------------------------------------------------------
// hex_ring_range_set
// Emits in index order every grid cell in a ring distance band around a centre.
// ----------------------------------------------------------------------------
module hex_ring_range_set (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_ready,
  input  hrrs_pkg::req_item_t req_data,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output hrrs_pkg::rsp_item_t rsp_data
);
  import hrrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  hrrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hrrs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire
